### sv/spc_pkg.sv
// Shared types and constants for the sorted priority queue.
// Used by spc_cell, sorted_priority_queue and spc_checker; no dependencies.
package spc_pkg;

    localparam int DEPTH          = 16;
    localparam int VALUE_WIDTH    = 32;
    localparam int PRIORITY_WIDTH = 16;
    localparam int CNT_W          = $clog2(DEPTH + 1);

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]                       op;
        logic signed [VALUE_WIDTH-1:0]    item_value;
        logic signed [PRIORITY_WIDTH-1:0] item_priority;
    } req_t;

    typedef struct packed {
        logic [1:0]                       status;
        logic                             is_empty;
        logic [CNT_W-1:0]                 occupancy;
        logic signed [VALUE_WIDTH-1:0]    head_value;
        logic signed [PRIORITY_WIDTH-1:0] head_priority;
        logic signed [VALUE_WIDTH-1:0]    tail_value;
    } rsp_t;

    typedef struct packed {
        logic                             valid;
        logic signed [VALUE_WIDTH-1:0]    value;
        logic signed [PRIORITY_WIDTH-1:0] prio;
    } entry_t;

    // Broadcast to every cell: the accepted operation and the new entry.
    typedef struct packed {
        logic                             push;
        logic                             pop;
        logic signed [VALUE_WIDTH-1:0]    value;
        logic signed [PRIORITY_WIDTH-1:0] prio;
    } cell_ctl_t;

endpackage

### sv/spc_cell.sv
// One slot of the sorted chain: holds an entry, compares against a pushed entry.
// Depends on spc_pkg.
module spc_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  spc_pkg::cell_ctl_t ctl,
    input  spc_pkg::entry_t    left_entry,
    input  logic               left_ins,
    input  spc_pkg::entry_t    right_entry,
    output spc_pkg::entry_t    entry,
    output logic               ins
);

    logic                                      valid_reg;
    logic                                      valid_next;
    logic signed [spc_pkg::VALUE_WIDTH-1:0]    value_reg;
    logic signed [spc_pkg::VALUE_WIDTH-1:0]    value_next;
    logic signed [spc_pkg::PRIORITY_WIDTH-1:0] prio_reg;
    logic signed [spc_pkg::PRIORITY_WIDTH-1:0] prio_next;

    // Insert point: first slot that is empty or holds a priority not above the new one.
    assign ins = !valid_reg || (prio_reg <= ctl.prio);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctl.push)
        begin
            if (left_ins)
            begin
                // shift down from the left neighbor
                valid_next = left_entry.valid;
                value_next = left_entry.value;
                prio_next  = left_entry.prio;
            end
            else if (ins)
            begin
                valid_next = 1'b1;
                value_next = ctl.value;
                prio_next  = ctl.prio;
            end
        end
        else if (ctl.pop)
        begin
            valid_next = right_entry.valid;
            value_next = right_entry.value;
            prio_next  = right_entry.prio;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign entry.valid = valid_reg;
    assign entry.value = value_reg;
    assign entry.prio  = prio_reg;

endmodule

### sv/sorted_priority_queue.sv
// Top level of the sorted priority queue: a chain of spc_cell slots plus control.
// Depends on spc_pkg and spc_cell.
//
// Usage:
//   Request channel (req_valid, req_stall, req): each request is a push of
//   (item_value, item_priority), a pop of the head, or a query (any other op).
//   Response channel (rsp_valid, rsp_stall, rsp): one response per request
//   with status and a snapshot of the queue after that request.
//   Entries are kept in descending priority order; a push lands ahead of the
//   first entry with equal or lower priority, so ties come out newest first.
//   A push on a full queue is dropped with status full; a pop on an empty
//   queue reports status empty. Both leave the queue unchanged.
// Timing:
//   One request per cycle while req_stall is low. The response appears in the cycle after acceptance.
//   Every cell compares and shifts in parallel in the same cycle, so the
//   compare across the chain plus one shift sets the cycle time.
// Reset:
//   rst_n clears all valid bits and the count; the queue starts empty.
// Stall:
//   While a response is held under rsp_stall, req_stall is raised and the
//   queue contents hold, so the shown snapshot stays stable.
module sorted_priority_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  spc_pkg::req_t   req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output spc_pkg::rsp_t   rsp
);

    localparam int N = spc_pkg::DEPTH;

    logic                           rsp_valid_reg;
    logic                           rsp_valid_next;
    logic [1:0]                     status_reg;
    logic [1:0]                     status_next;
    logic [spc_pkg::CNT_W-1:0]      count_reg;
    logic [spc_pkg::CNT_W-1:0]      count_next;

    logic                           accept;
    logic                           is_full;
    logic                           is_empty;
    spc_pkg::cell_ctl_t             ctl;
    spc_pkg::entry_t                cell_entry [N];
    logic [N-1:0]                   cell_ins;
    logic [N:0]                     valid_vec;
    logic signed [spc_pkg::VALUE_WIDTH-1:0] tail_value;

    // Hold the request side while a response is still waiting.
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    assign is_full  = (count_reg == spc_pkg::CNT_W'(N));
    assign is_empty = (count_reg == '0);

    // Drop rejected operations before they reach the cells.
    assign ctl.push  = accept && (req.op == spc_pkg::OP_PUSH) && !is_full;
    assign ctl.pop   = accept && (req.op == spc_pkg::OP_POP) && !is_empty;
    assign ctl.value = req.item_value;
    assign ctl.prio  = req.item_priority;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            spc_pkg::entry_t left_e;
            spc_pkg::entry_t right_e;
            logic            left_i;
            if (gi == 0)
            begin : g_first
                assign left_e = '0;
                assign left_i = 1'b0;
            end
            else
            begin : g_mid
                assign left_e = cell_entry[gi-1];
                assign left_i = cell_ins[gi-1];
            end
            if (gi == N - 1)
            begin : g_last
                assign right_e = '0;
            end
            else
            begin : g_inner
                assign right_e = cell_entry[gi+1];
            end

            spc_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .left_entry  (left_e),
                .left_ins    (left_i),
                .right_entry (right_e),
                .entry       (cell_entry[gi]),
                .ins         (cell_ins[gi])
            );
            assign valid_vec[gi] = cell_entry[gi].valid;
        end
    endgenerate
    assign valid_vec[N] = 1'b0;

    // Tail is the last valid slot: at most one cell sees valid followed by empty.
    always_comb
    begin
        tail_value = '0;
        for (int i = 0; i < N; i++)
        begin
            if (valid_vec[i] && !valid_vec[i+1])
            begin
                tail_value = tail_value | cell_entry[i].value;
            end
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            status_next    = spc_pkg::ST_OK;
            if (req.op == spc_pkg::OP_PUSH)
            begin
                if (is_full)
                begin
                    status_next = spc_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            else if (req.op == spc_pkg::OP_POP)
            begin
                if (is_empty)
                begin
                    status_next = spc_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            status_reg    <= spc_pkg::ST_OK;
            count_reg     <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            status_reg    <= status_next;
            count_reg     <= count_next;
        end
    end

    // Snapshot comes straight from the cells; they hold while the response waits.
    assign rsp_valid         = rsp_valid_reg;
    assign rsp.status        = status_reg;
    assign rsp.is_empty      = is_empty;
    assign rsp.occupancy     = count_reg;
    assign rsp.head_value    = cell_entry[0].valid ? cell_entry[0].value : '0;
    assign rsp.head_priority = cell_entry[0].valid ? cell_entry[0].prio : '0;
    assign rsp.tail_value    = tail_value;

endmodule

### sv/spc_checker.sv
// Port-level checks for sorted_priority_queue, attached by bind.
// Depends on spc_pkg and sorted_priority_queue.
module spc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input spc_pkg::rsp_t rsp
);

    // A held response keeps its contents.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // Every accepted request yields a response in the next cycle.
    a_req_to_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> rsp_valid)
        else $error("accepted request produced no response");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.is_empty == (rsp.occupancy == '0))
                      && (rsp.occupancy <= spc_pkg::CNT_W'(spc_pkg::DEPTH)))
        else $error("occupancy and empty flag disagree");

    a_status_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status != spc_pkg::ST_FULL
                       || rsp.occupancy == spc_pkg::CNT_W'(spc_pkg::DEPTH))
                   && (rsp.status != spc_pkg::ST_EMPTY || rsp.occupancy == '0))
        else $error("rejection status with wrong occupancy");

    // Queue change per response is at most one entry.
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_stall ##1 rsp_valid && $changed(rsp.occupancy) |->
            (rsp.occupancy == $past(rsp.occupancy) + 1'b1)
            || (rsp.occupancy == $past(rsp.occupancy) - 1'b1))
        else $error("occupancy jumped by more than one");

endmodule

bind sorted_priority_queue spc_checker u_spc_checker (.*);
